// File: rtl/core/ltr_pkg.sv
package ltr_pkg;

  localparam int unsigned LtrTileCount = 512;

  localparam logic [10:0] LineLast     = 11'd1231;
  localparam logic [10:0] DrawEnd      = 11'd960;
  localparam logic [7:0]  VisibleLines = 8'd160;
  localparam logic [7:0]  FrameLast    = 8'd227;
  localparam logic [7:0]  AlphaOpaque  = 8'hFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_MAP   = 2'd1,
    OP_TILE  = 2'd2,
    OP_PAL   = 2'd3
  } ltr_op_e;

  typedef enum logic [1:0] {
    MODE_DRAW   = 2'd0,
    MODE_HBLANK = 2'd1,
    MODE_VBLANK = 2'd2
  } ltr_mode_e;

  typedef struct packed {
    logic       pix;
    logic [7:0] px;
    logic [7:0] py;
    logic [1:0] mode;
    logic       hirq;
    logic       virq;
    logic [7:0] line;
  } ltr_tick_t;

endpackage

// File: rtl/core/ltr_ifs.sv
interface ltr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [13:0] index;
  logic [15:0] value;

  modport source(output valid, output op, output index, output value, input ready);
  modport sink(input valid, input op, input index, input value, output ready);
endinterface

interface ltr_rsp_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [31:0] pixel_argb;
  logic [1:0]  scan_mode;
  logic        hblank_irq;
  logic        vblank_irq;
  logic [7:0]  line_number;

  modport source(
    output valid, output pixel_valid, output pixel_x, output pixel_y, output pixel_argb,
    output scan_mode, output hblank_irq, output vblank_irq, output line_number,
    input ready
  );
  modport sink(
    input valid, input pixel_valid, input pixel_x, input pixel_y, input pixel_argb,
    input scan_mode, input hblank_irq, input vblank_irq, input line_number,
    output ready
  );
endinterface

// File: rtl/core/ltr_timing.sv
module ltr_timing
  import ltr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      tick_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  output ltr_tick_t tim_o
);

  logic [10:0] pos_q, pos_d;
  logic [7:0]  line_q, line_d;
  logic [1:0]  mode_q, mode_d;
  logic        blank_q;

  always_comb begin
    logic active;
    logic vis;
    active = tick_i && !blank_q;
    vis = line_q < VisibleLines;
    tim_o = '0;
    tim_o.line = line_q;
    mode_d = mode_q;
    if (active) begin
      if (vis) begin
        if (pos_q < DrawEnd) begin
          mode_d = MODE_DRAW;
          if (pos_q[1:0] == 2'd0) begin
            tim_o.pix = 1'b1;
            tim_o.px = pos_q[9:2];
            tim_o.py = line_q;
          end
        end else begin
          mode_d = MODE_HBLANK;
        end
      end else begin
        mode_d = MODE_VBLANK;
        tim_o.virq = (line_q == VisibleLines) && (pos_q == 11'd0);
      end
      tim_o.hirq = pos_q == DrawEnd;
    end
    tim_o.mode = mode_d;

    pos_d = pos_q;
    line_d = line_q;
    if (tick_i) begin
      if (pos_q == LineLast) begin
        pos_d = 11'd0;
        line_d = (line_q == FrameLast) ? 8'd0 : line_q + 8'd1;
      end else begin
        pos_d = pos_q + 11'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      line_q <= '0;
      mode_q <= MODE_DRAW;
      blank_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      line_q <= line_d;
      mode_q <= mode_d;
      if (cfg_we_i) begin
        blank_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: rtl/core/lcd_timing_tile_renderer_unit.sv
// Tile background LCD timing unit with pixel generation.
// Requests enter on req_i: op selects a tick or a write of the map, tile or
// palette store, with index and value as write address and data. Each tick is
// one LCD clock; every request gives exactly one response on rsp_o, carrying
// the pixel of that clock (if any), the LCD mode, the interrupt pulses and the
// line number seen before the counters move.
// The cfg_we_i / cfg_wdata_i port sets forced blank, which stops pixels and
// pulses while the counters keep running.
// Throughput is one request per cycle while the receiver takes responses.
// The path is the map read, the tile number reduction (a quotient register,
// then a remainder register), the tile read and the palette read, each store
// written in the same stage where it is read, so accesses keep request order.
// A stalled receiver freezes the whole pipeline and drops req_i.ready until
// the output register is taken. Reset clears counters, mode, forced blank
// and pipeline valid bits; the stores hold unknown contents until written.
module lcd_timing_tile_renderer_unit
  import ltr_pkg::*;
#(
  parameter int unsigned TILE_COUNT = LtrTileCount
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ltr_req_if.sink  req_i,
  ltr_rsp_if.source rsp_o,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i
);

  localparam int unsigned TileDepth = TILE_COUNT * 32;
  localparam int unsigned Taw = $clog2(TileDepth);
  localparam logic [27:0] Recip = 28'((1 << 27) / TILE_COUNT);
  localparam logic [16:0] TileDepthW = 17'(TileDepth);
  localparam logic [15:0] TileCountW = 16'(TILE_COUNT);

  typedef struct packed {
    logic       pix;
    logic [7:0] px;
    logic [7:0] py;
    logic [1:0] op;
    logic [13:0] idx;
    logic [15:0] val;
    logic [1:0] mode;
    logic       hirq;
    logic       virq;
    logic [7:0] line;
  } item_t;

  logic [15:0] map_mem [1024];
  logic [7:0]  tile_mem [TileDepth];
  logic [15:0] pal_mem [16];

  logic adv;
  logic in_acc;
  ltr_tick_t tim;
  item_t s0;

  logic  s1_v, s2_v, s3_v, s4_v, s5_v;
  item_t s1_q, s2_q, s3_q, s4_q, s5_q;
  logic [15:0] map_rd_q;
  logic [15:0] quot_q, entry_q;
  logic [15:0] rraw_q;
  logic [7:0]  tile_rd_q;
  logic [15:0] pal_rd_q;

  logic [43:0] recip_prod;
  logic [27:0] back_prod;
  logic [15:0] rcorr;
  logic [20:0] tile_rsum, tile_wsum;
  logic [Taw-1:0] tile_raddr, tile_waddr;
  logic [3:0] nib;
  logic [9:0] map_cell;

  assign adv = !s5_v || rsp_o.ready;
  assign req_i.ready = adv;
  assign in_acc = adv && req_i.valid;

  ltr_timing u_timing (
    .clk_i,
    .rst_ni,
    .tick_i(in_acc && (req_i.op == OP_TICK)),
    .cfg_we_i,
    .cfg_wdata_i,
    .tim_o(tim)
  );

  always_comb begin
    s0.pix = tim.pix;
    s0.px = tim.px;
    s0.py = tim.py;
    s0.op = req_i.op;
    s0.idx = req_i.index;
    s0.val = req_i.value;
    s0.mode = tim.mode;
    s0.hirq = tim.hirq;
    s0.virq = tim.virq;
    s0.line = tim.line;
  end

  assign map_cell = {tim.py[7:3], tim.px[7:3]};
  assign recip_prod = 44'(map_rd_q) * 44'(Recip);
  assign back_prod = 28'(quot_q) * 28'(TILE_COUNT);
  assign rcorr = (rraw_q >= TileCountW) ? rraw_q - TileCountW : rraw_q;
  assign tile_rsum = {rcorr, s3_q.py[2:0], s3_q.px[2:1]};
  assign tile_raddr = tile_rsum[Taw-1:0];
  assign tile_wsum = 21'(s3_q.idx);
  assign tile_waddr = tile_wsum[Taw-1:0];
  assign nib = s4_q.px[0] ? tile_rd_q[7:4] : tile_rd_q[3:0];

  always_ff @(posedge clk_i) begin
    if (in_acc && (req_i.op == OP_MAP)) begin
      map_mem[req_i.index[9:0]] <= req_i.value;
    end
    if (adv) begin
      map_rd_q <= map_mem[map_cell];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_v && (s3_q.op == OP_TILE) && ({3'b0, s3_q.idx} < TileDepthW)) begin
      tile_mem[tile_waddr] <= s3_q.val[7:0];
    end
    if (adv) begin
      tile_rd_q <= tile_mem[tile_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s4_v && (s4_q.op == OP_PAL)) begin
      pal_mem[s4_q.idx[3:0]] <= s4_q.val;
    end
    if (adv) begin
      pal_rd_q <= pal_mem[nib];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s0;
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;
      s5_q <= s4_q;
      quot_q <= recip_prod[42:27];
      entry_q <= map_rd_q;
      rraw_q <= entry_q - back_prod[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else if (adv) begin
      s1_v <= req_i.valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
    end
  end

  assign rsp_o.valid = s5_v;
  assign rsp_o.pixel_valid = s5_q.pix;
  assign rsp_o.pixel_x = s5_q.px;
  assign rsp_o.pixel_y = s5_q.py;
  assign rsp_o.pixel_argb = s5_q.pix ?
    {AlphaOpaque, pal_rd_q[4:0], 3'b0, pal_rd_q[9:5], 3'b0, pal_rd_q[14:10], 3'b0} : 32'd0;
  assign rsp_o.scan_mode = s5_q.mode;
  assign rsp_o.hblank_irq = s5_q.hirq;
  assign rsp_o.vblank_irq = s5_q.virq;
  assign rsp_o.line_number = s5_q.line;

  a_pix_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_v && s5_q.pix |-> (s5_q.mode == MODE_DRAW) && (s5_q.py == s5_q.line)
      && (s5_q.line < VisibleLines))
    else $error("pixel delivered outside the drawing period");

  a_hirq_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_v && s5_q.hirq |-> (s5_q.mode != MODE_DRAW) && !s5_q.pix)
    else $error("hblank pulse during drawing");

  a_virq_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_v && s5_q.virq |-> (s5_q.mode == MODE_VBLANK) && (s5_q.line == VisibleLines))
    else $error("vblank pulse on the wrong line");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v && !adv |=> s1_v && $stable(s1_q))
    else $error("pipeline stage moved during a stall");

endmodule
